### rtl/ptach_pkg.sv
// Shared types and constants for the period capture tachometer.
`timescale 1ns / 1ps
package ptach_pkg;

	localparam int CAP_W     = 16;
	localparam int TICK_W    = 10;
	localparam int SPEED_W   = 21;
	localparam int IDLE_W    = 17;
	localparam int RATIO_W   = 8;
	localparam int TIMEOUT_W = 16;
	localparam int CFG_W     = 16;
	localparam int CNT_W     = $clog2(SPEED_W);

	localparam logic [SPEED_W-1:0]   SPEED_NUM     = SPEED_W'(1920000);
	localparam logic [IDLE_W-1:0]    IDLE_MAX      = {IDLE_W{1'b1}};
	localparam logic [RATIO_W-1:0]   RATIO_RESET   = RATIO_W'(1);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000);
	localparam logic [CNT_W-1:0]     DIV_LAST      = CNT_W'(SPEED_W - 1);

	// register indexes
	localparam logic REG_GEAR_RATIO   = 1'b0;
	localparam logic REG_STOP_TIMEOUT = 1'b1;

	// operation codes
	localparam logic OP_CAPTURE = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_LOAD
	} ptach_state_t;

	typedef struct packed {
		logic accept_cap;  // capture item taken: latch period
		logic accept_tick; // tick item taken: update idle timer
		logic mul;         // form denominator, arm divider
		logic div_step;    // one restoring division step
		logic div_last;    // final step: commit speed
		logic load;        // move result into output register
	} ptach_cmd_t;

endpackage

### rtl/ptach_ctrl.sv
// Controller state machine for the period capture tachometer.
`timescale 1ns / 1ps
module ptach_ctrl import ptach_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       operation,
	output logic       out_valid,
	input  logic       out_stall,
	output ptach_cmd_t cmd
);

	ptach_state_t     state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (operation == OP_TICK) ? ST_LOAD : ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall        = 1'b0;
				cmd.accept_cap  = accept && (operation == OP_CAPTURE);
				cmd.accept_tick = accept && (operation == OP_TICK);
			end
			ST_MUL:  cmd.mul = 1'b1;
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_last = (cnt_q == DIV_LAST);
			end
			ST_LOAD: cmd.load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.mul) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/ptach_dp.sv
// Datapath: period, multiplier, bit-serial divider, idle timer, config and result registers.
`timescale 1ns / 1ps
module ptach_dp import ptach_pkg::*; #(
	parameter int TIMER_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptach_cmd_t           cmd,
	input  logic [CAP_W-1:0]     capture_value,
	input  logic [TICK_W-1:0]    tick_ms,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic [SPEED_W-1:0]   speed_q4,
	output logic                 stopped
);

	localparam int DIFF_W = TIMER_BITS + 1;
	localparam int DEN_W  = DIFF_W + RATIO_W;

	logic [RATIO_W-1:0]    ratio_q;
	logic [TIMEOUT_W-1:0]  timeout_q;
	logic [TIMER_BITS-1:0] last_q;
	logic [IDLE_W-1:0]     idle_q;
	logic [SPEED_W-1:0]    speed_value_q;
	logic                  stop_flag_q;
	logic [DIFF_W-1:0]     diff_q;
	logic [DEN_W-1:0]      denom_q;
	logic [DEN_W-1:0]      rem_q;
	logic [SPEED_W-1:0]    dvd_q;
	logic [SPEED_W-1:0]    quo_q;
	logic [SPEED_W-1:0]    speed_q;
	logic                  stopped_q;

	logic [TIMER_BITS+CAP_W-1:0] cap_wide;
	logic [TIMER_BITS-1:0]       now;
	logic [TIMER_BITS-1:0]       diff_mod;
	logic [DIFF_W-1:0]           diff;
	logic [RATIO_W-1:0]          ratio_eff;
	logic [DEN_W-1:0]            product;
	logic [DEN_W:0]              trial;
	logic                        ge;
	logic [DEN_W:0]              trial_sub;
	logic [DEN_W-1:0]            rem_next;
	logic [SPEED_W-1:0]          quo_next;
	logic [IDLE_W:0]             idle_sum;
	logic [IDLE_W-1:0]           idle_sat;
	logic                        hit;

	// period: modular difference, zero meaning one full timer wrap
	assign cap_wide  = {{TIMER_BITS{1'b0}}, capture_value};
	assign now       = cap_wide[TIMER_BITS-1:0];
	assign diff_mod  = now - last_q;
	assign diff      = (diff_mod == '0) ? {1'b1, {TIMER_BITS{1'b0}}} : {1'b0, diff_mod};

	assign ratio_eff = (ratio_q == '0) ? RATIO_W'(1) : ratio_q;
	assign product   = DEN_W'(diff_q) * DEN_W'(ratio_eff);

	// restoring division, one quotient bit per cycle
	assign trial     = {rem_q, dvd_q[SPEED_W-1]};
	assign ge        = trial >= {1'b0, denom_q};
	assign trial_sub = trial - {1'b0, denom_q};
	assign rem_next  = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
	assign quo_next  = {quo_q[SPEED_W-2:0], ge};

	assign idle_sum  = {1'b0, idle_q} + (IDLE_W+1)'(tick_ms);
	assign idle_sat  = (idle_sum > {1'b0, IDLE_MAX}) ? IDLE_MAX : idle_sum[IDLE_W-1:0];
	assign hit       = idle_sat >= IDLE_W'(timeout_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q       <= RATIO_RESET;
			timeout_q     <= TIMEOUT_RESET;
			last_q        <= '0;
			idle_q        <= '0;
			speed_value_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_GEAR_RATIO) begin
					ratio_q <= cfg_data[RATIO_W-1:0];
				end else begin
					timeout_q <= cfg_data[TIMEOUT_W-1:0];
				end
			end
			if (cmd.accept_cap) begin
				last_q <= now;
			end
			if (cmd.accept_tick) begin
				if (hit) begin
					idle_q        <= '0;
					speed_value_q <= '0;
				end else begin
					idle_q <= idle_sat;
				end
			end
			if (cmd.div_last) begin
				speed_value_q <= quo_next;
				idle_q        <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_cap) begin
			diff_q      <= diff;
			stop_flag_q <= 1'b0;
		end
		if (cmd.accept_tick) begin
			stop_flag_q <= hit;
		end
		if (cmd.mul) begin
			denom_q <= product;
			rem_q   <= '0;
			dvd_q   <= SPEED_NUM;
			quo_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[SPEED_W-2:0], 1'b0};
			quo_q <= quo_next;
		end
		if (cmd.load) begin
			speed_q   <= speed_value_q;
			stopped_q <= stop_flag_q;
		end
	end

	assign speed_q4 = speed_q;
	assign stopped  = stopped_q;

endmodule

### rtl/period_capture_tachometer_unit.sv
// Top level of the period capture tachometer.
`timescale 1ns / 1ps
// Input-capture tachometer. A capture item (operation 0) takes the timer count,
// forms the period modulo 2^TIMER_BITS (equal counts mean a full wrap),
// multiplies by the gear ratio register and divides 1920000 by it to give speed
// in 1/16 rpm; it clears the idle timer. A tick item (operation 1) adds tick_ms
// to the idle timer and, on reaching stop_timeout_ms, zeroes speed and raises stopped.
// Every item yields one result. A capture item latches the period, forms the product in
// the multiply state, runs the bit-serial restoring divider (one quotient bit per cycle)
// and loads the output register; a tick item goes from the accept straight to the load.
// A finished result waits in the output register, and the block accepts the next item
// as soon as that register is loaded. The user must make configuration writes only
// while no item is in flight; the block itself does not enforce this.
module period_capture_tachometer_unit import ptach_pkg::*; #(
	parameter int TIMER_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 operation,
	input  logic [CAP_W-1:0]     capture_value,
	input  logic [TICK_W-1:0]    tick_ms,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SPEED_W-1:0]   speed_q4,
	output logic                 stopped,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	ptach_cmd_t cmd;

	ptach_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	ptach_dp #(
		.TIMER_BITS (TIMER_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.capture_value (capture_value),
		.tick_ms       (tick_ms),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.speed_q4      (speed_q4),
		.stopped       (stopped)
	);

	// once an item is taken the block is busy the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after an item was taken");

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stopped) |-> (speed_q4 == '0))
		else $error("stopped result with nonzero speed");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (speed_q4 <= SPEED_NUM))
		else $error("speed beyond full scale");

	// a result is loaded only on the way back to idle
	a_load_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_stall)
		else $error("output loaded without returning to idle");

endmodule

### bench/tb_top.sv
// Self-checking bench for the period capture tachometer: directed table, then random items.
`timescale 1ns / 1ps
module tb_top;
	import ptach_pkg::*;

	localparam int SETTLE_CYCLES = 32;
	localparam int QUIET_LIMIT   = 4000;
	localparam int SEG_COUNT     = 8;
	localparam int SEG_ITEMS     = 216;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic               stopped;
	} tach_out_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic               op;
		logic [CAP_W-1:0]   cap;
		logic [TICK_W-1:0]  tick;
		logic               reg_idx;
		logic [CFG_W-1:0]   reg_val;
		logic               pinned;
		logic [SPEED_W-1:0] pin_speed;
		logic               pin_stop;
	} dir_row_t;

	localparam int DIR_ROWS = 27;

	// pinned rows carry a value worked out by hand; the rest go through the model below
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_ITEM, OP_CAPTURE, 16'h0000, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b1, 21'd29, 1'b0},
		'{ROW_ITEM, OP_CAPTURE, 16'h0001, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b1, 21'd1920000, 1'b0},
		'{ROW_ITEM, OP_CAPTURE, 16'hFFFF, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b0, 21'd0, 1'b0},
		'{ROW_ITEM, OP_CAPTURE, 16'h0000, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b1, 21'd1920000, 1'b0},
		'{ROW_ITEM, OP_TICK, 16'h0000, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b1, 21'd1920000, 1'b0},
		'{ROW_ITEM, OP_TICK, 16'h0000, 10'd999, REG_GEAR_RATIO, 16'd0, 1'b0, 21'd0, 1'b0},
		'{ROW_ITEM, OP_TICK, 16'h0000, 10'd1, REG_GEAR_RATIO, 16'd0, 1'b1, 21'd0, 1'b1},
		'{ROW_ITEM, OP_TICK, 16'h0000, 10'd1023, REG_GEAR_RATIO, 16'd0, 1'b1, 21'd0, 1'b1},
		'{ROW_ITEM, OP_CAPTURE, 16'h8000, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b0, 21'd0, 1'b0},
		'{ROW_ITEM, OP_TICK, 16'h0000, 10'd500, REG_GEAR_RATIO, 16'd0, 1'b0, 21'd0, 1'b0},
		'{ROW_ITEM, OP_CAPTURE, 16'h8001, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b1, 21'd1920000, 1'b0},
		'{ROW_ITEM, OP_TICK, 16'h0000, 10'd999, REG_GEAR_RATIO, 16'd0, 1'b0, 21'd0, 1'b0},
		'{ROW_ITEM, OP_TICK, 16'h0000, 10'd1, REG_GEAR_RATIO, 16'd0, 1'b1, 21'd0, 1'b1},
		'{ROW_REG, OP_CAPTURE, 16'h0000, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b0, 21'd0, 1'b0},
		'{ROW_ITEM, OP_CAPTURE, 16'h8003, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b1, 21'd960000, 1'b0},
		'{ROW_REG, OP_CAPTURE, 16'h0000, 10'd0, REG_GEAR_RATIO, 16'd255, 1'b0, 21'd0, 1'b0},
		'{ROW_ITEM, OP_CAPTURE, 16'h8004, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b1, 21'd7529, 1'b0},
		'{ROW_ITEM, OP_CAPTURE, 16'h8004, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b1, 21'd0, 1'b0},
		'{ROW_REG, OP_CAPTURE, 16'h0000, 10'd0, REG_STOP_TIMEOUT, 16'd0, 1'b0, 21'd0, 1'b0},
		'{ROW_ITEM, OP_CAPTURE, 16'h8005, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b1, 21'd7529, 1'b0},
		'{ROW_ITEM, OP_TICK, 16'h0000, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b1, 21'd0, 1'b1},
		'{ROW_REG, OP_CAPTURE, 16'h0000, 10'd0, REG_STOP_TIMEOUT, 16'hFFFF, 1'b0, 21'd0, 1'b0},
		'{ROW_REG, OP_CAPTURE, 16'h0000, 10'd0, REG_GEAR_RATIO, 16'd1, 1'b0, 21'd0, 1'b0},
		'{ROW_ITEM, OP_CAPTURE, 16'h5555, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b0, 21'd0, 1'b0},
		'{ROW_ITEM, OP_CAPTURE, 16'hAAAA, 10'd0, REG_GEAR_RATIO, 16'd0, 1'b0, 21'd0, 1'b0},
		'{ROW_ITEM, OP_TICK, 16'h0000, 10'h2AA, REG_GEAR_RATIO, 16'd0, 1'b0, 21'd0, 1'b0},
		'{ROW_ITEM, OP_TICK, 16'h0000, 10'h155, REG_GEAR_RATIO, 16'd0, 1'b0, 21'd0, 1'b0}
	};

	// -1 means pick at random for that segment
	int seg_ratio [SEG_COUNT]   = '{1, 255, -1, 0, -1, 2, -1, 1};
	int seg_timeout [SEG_COUNT] = '{1000, 65535, 1, -1, 0, -1, 2000, 65535};
	int send_pct_tab [4]        = '{0, 78, 0, 19};
	int stall_pct_tab [4]       = '{0, 0, 78, 19};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               operation = OP_CAPTURE;
	logic [CAP_W-1:0]   capture_value = '0;
	logic [TICK_W-1:0]  tick_ms = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [SPEED_W-1:0] speed_q4;
	logic               stopped;
	logic               cfg_wr_en = 1'b0;
	logic               cfg_index = REG_GEAR_RATIO;
	logic [CFG_W-1:0]   cfg_data = '0;

	// hand-worked expectation travels with the item on the input side
	logic               pin_has = 1'b0;
	logic [SPEED_W-1:0] pin_speed = '0;
	logic               pin_stop = 1'b0;

	int send_idle_pct = 19;
	int recv_stall_pct = 19;
	int errors = 0;
	int quiet_cycles = 0;

	// model state
	logic [RATIO_W-1:0]   m_ratio = RATIO_RESET;
	logic [TIMEOUT_W-1:0] m_timeout = TIMEOUT_RESET;
	logic [CAP_W-1:0]     m_last_cap = '0;
	logic [IDLE_W-1:0]    m_idle = '0;
	logic [SPEED_W-1:0]   m_speed = '0;

	logic [CAP_W-1:0]     gen_last_cap = '0;

	tach_out_t pending_speeds [$];

	period_capture_tachometer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.capture_value(capture_value),
		.tick_ms      (tick_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.speed_q4     (speed_q4),
		.stopped      (stopped),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the model by one item and return the speed and stopped flag it reports
	function automatic tach_out_t next_speed(logic op, logic [CAP_W-1:0] cap,
			logic [TICK_W-1:0] tk);
		tach_out_t           res;
		logic [CAP_W-1:0]    cap_diff;
		longint unsigned     period;
		longint unsigned     ratio;
		logic [IDLE_W:0]     sum;
		res.stopped = 1'b0;
		if (op == OP_CAPTURE) begin
			cap_diff = cap - m_last_cap;
			period = 64'(cap_diff);
			if (period == 0)
				period = 64'd65536; // equal counts: one full timer wrap
			ratio = (m_ratio == '0) ? 64'd1 : longint'(m_ratio);
			m_speed = SPEED_W'(64'd1920000 / (period * ratio));
			m_last_cap = cap;
			m_idle = '0;
		end else begin
			sum = {1'b0, m_idle} + (IDLE_W + 1)'(tk);
			m_idle = (sum > {1'b0, IDLE_MAX}) ? IDLE_MAX : sum[IDLE_W-1:0];
			if (m_idle >= IDLE_W'(m_timeout)) begin
				m_speed = '0;
				m_idle = '0;
				res.stopped = 1'b1;
			end
		end
		res.speed = m_speed;
		return res;
	endfunction

	always @(posedge clk) begin : monitor
		tach_out_t exp_r;
		logic      active;
		if (arst_n) begin
			active = 1'b0;
			if (cfg_wr_en) begin
				active = 1'b1;
				if (cfg_index == REG_GEAR_RATIO)
					m_ratio = cfg_data[RATIO_W-1:0];
				else
					m_timeout = cfg_data;
			end
			if (in_valid && !in_stall) begin
				active = 1'b1;
				exp_r = next_speed(operation, capture_value, tick_ms);
				if (pin_has) begin
					exp_r.speed = pin_speed;
					exp_r.stopped = pin_stop;
				end
				pending_speeds.push_back(exp_r);
			end
			if (out_valid && !out_stall) begin
				active = 1'b1;
				if (pending_speeds.size() == 0) begin
					errors++;
					$display("%0t: unexpected result speed_q4=%0d stopped=%0b",
						$time, speed_q4, stopped);
				end else begin
					exp_r = pending_speeds.pop_front();
					if (speed_q4 !== exp_r.speed) begin
						errors++;
						$display("%0t: speed_q4 expected %0d got %0d",
							$time, exp_r.speed, speed_q4);
					end
					if (stopped !== exp_r.stopped) begin
						errors++;
						$display("%0t: stopped expected %0b got %0b",
							$time, exp_r.stopped, stopped);
					end
				end
			end
			quiet_cycles = active ? 0 : quiet_cycles + 1;
		end
	end

	always @(posedge clk)
		out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("FAIL period_capture_tachometer_unit");
		$finish;
	end

	task automatic send_item(logic op, logic [CAP_W-1:0] cap, logic [TICK_W-1:0] tk,
			logic pinned, logic [SPEED_W-1:0] p_speed, logic p_stop);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		capture_value <= cap;
		tick_ms <= tk;
		pin_has <= pinned;
		pin_speed <= p_speed;
		pin_stop <= p_stop;
		if (op == OP_CAPTURE)
			gen_last_cap = cap;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// block must be empty before a register write; wait on the clock first so the
	// monitor has queued the last item taken
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_speeds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_capture();
		int                r;
		logic [CAP_W-1:0]  delta;
		r = $urandom_range(99);
		if (r < 40)
			delta = CAP_W'($urandom_range(1, 64));
		else if (r < 70)
			delta = CAP_W'($urandom_range(65, 4095));
		else if (r < 90)
			delta = CAP_W'($urandom);
		else
			delta = '0;
		send_item(OP_CAPTURE, gen_last_cap + delta, TICK_W'($urandom), 1'b0, '0, 1'b0);
	endtask

	initial begin : stimulus
		int ratio_v;
		int timeout_v;
		int sent;
		int burst;
		int r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_REG) begin
				drain();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				send_item(dir_rows[i].op, dir_rows[i].cap, dir_rows[i].tick,
					dir_rows[i].pinned, dir_rows[i].pin_speed, dir_rows[i].pin_stop);
			end
		end

		for (int seg = 0; seg < SEG_COUNT; seg++) begin
			drain();
			ratio_v = (seg_ratio[seg] < 0) ? $urandom_range(1, 255) : seg_ratio[seg];
			timeout_v = (seg_timeout[seg] < 0) ? $urandom_range(20, 5000) : seg_timeout[seg];
			write_reg(REG_GEAR_RATIO, CFG_W'(ratio_v));
			write_reg(REG_STOP_TIMEOUT, CFG_W'(timeout_v));
			send_idle_pct = send_pct_tab[seg % 4];
			recv_stall_pct <= stall_pct_tab[seg % 4];
			sent = 0;
			while (sent < SEG_ITEMS) begin
				r = $urandom_range(99);
				if (r < 45) begin
					random_capture();
					sent++;
				end else if (r < 95) begin
					send_item(OP_TICK, CAP_W'($urandom), TICK_W'($urandom), 1'b0, '0, 1'b0);
					sent++;
				end else begin
					// long run without captures so that large timeouts get hit
					burst = $urandom_range(20, 70);
					for (int k = 0; k < burst; k++)
						send_item(OP_TICK, CAP_W'($urandom), TICK_W'($urandom_range(900, 1023)),
							1'b0, '0, 1'b0);
					sent += burst;
				end
			end
		end

		drain();
		if (errors == 0)
			$display("PASS period_capture_tachometer_unit");
		else
			$display("FAIL period_capture_tachometer_unit");
		$finish;
	end

endmodule

### period_capture_tachometer_unit.f
rtl/ptach_pkg.sv
rtl/ptach_ctrl.sv
rtl/ptach_dp.sv
rtl/period_capture_tachometer_unit.sv
bench/tb_top.sv
